// ===== rtl/myers_substring_edit_distance_top_assert.svh =====
// Assertion macros shared by the RTL files.
`ifndef MYERS_SUBSTRING_EDIT_DISTANCE_TOP_ASSERT_SVH
`define MYERS_SUBSTRING_EDIT_DISTANCE_TOP_ASSERT_SVH

// Condition holds at every edge outside reset.
`define MSE_ASSERT_HOLDS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define MSE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define MSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mse_pkg.sv =====
package mse_pkg;

   localparam int QUERY_MAX_DEF     = 64;
   localparam int ASCII_ENTRIES_DEF = 128;
   localparam int POSITION_BITS_DEF = 16;

   localparam int CP_W      = 21;
   localparam int OP_W      = 2;
   localparam int DIST_W    = 7;
   localparam int POS_OUT_W = 16;
   localparam int CSR_W     = 8;

   localparam logic [OP_W-1:0] OP_QUERY  = 2'd0;
   localparam logic [OP_W-1:0] OP_TEXT   = 2'd1;
   localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0] opcode;
      logic [CP_W-1:0] codepoint;
   } req_item_type;

   typedef struct packed {
      logic                 matched;
      logic [DIST_W-1:0]    distance;
      logic [POS_OUT_W-1:0] end_position;
   } rsp_item_type;

   // write strobes into the match store
   typedef struct packed {
      logic ascii_we;
      logic wide_we;
      logic code_we;
   } store_wr_type;

   // per-item control for the column update
   typedef struct packed {
      logic text;
      logic finish;
      logic active;
   } step_ctl_type;

endpackage

// ===== rtl/myers_substring_edit_distance_top.sv =====
// A finish item's result is registered into rsp_valid and rsp_item as the item leaves stage s2.
// Throughput: one item per cycle unless the input stalls; the last stage updates the 64-bit column vectors,
// and both match memories are read in the stages ahead of it, with the two latest writes forwarded.
// The input stalls only while a finish item waits for a held result to be taken.
// Reset (synchronous): clears the job, the ASCII entry flags and max distance; no clearing pass.
`include "myers_substring_edit_distance_top_assert.svh"

module myers_substring_edit_distance_top #(
   parameter int QUERY_MAX     = mse_pkg::QUERY_MAX_DEF,
   parameter int ASCII_ENTRIES = mse_pkg::ASCII_ENTRIES_DEF,
   parameter int POSITION_BITS = mse_pkg::POSITION_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  mse_pkg::req_item_type       req_item,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output mse_pkg::rsp_item_type       rsp_item,
   input  logic                        csr_wr_en,
   input  logic [mse_pkg::CSR_W-1:0]   csr_wr_data
);

   localparam int VEC_W  = QUERY_MAX;
   localparam int LEN_W  = $clog2(QUERY_MAX + 1);
   localparam int WIDX_W = $clog2(QUERY_MAX);
   localparam int AIDX_W = $clog2(ASCII_ENTRIES);

   typedef struct packed {
      logic                     valid;
      logic                     wide;
      logic                     append;
      logic [AIDX_W-1:0]        aidx;
      logic [WIDX_W-1:0]        widx;
      logic [mse_pkg::CP_W-1:0] code;
      logic [VEC_W-1:0]         data;
   } fwd_type;

   logic advance, accept, out_free, s2_finish_fire;
   logic s1_valid_ff, s2_valid_ff, s1_stale_ff, s2_stale_ff;
   mse_pkg::req_item_type s1_item_ff, s2_item_ff;

   logic [LEN_W-1:0] qlen_ff, count_ff;
   logic too_long_ff;
   logic [mse_pkg::CSR_W-1:0] csr_ff;
   fwd_type hist1_ff, hist1_in, hist2_ff, hist2_in;

   logic rsp_valid_ff;
   mse_pkg::rsp_item_type rsp_item_ff, rsp_item_in;

   logic [VEC_W-1:0] st_ascii_rd, st_wide_rd;
   logic st_wide_hit;
   logic [WIDX_W-1:0] st_wide_idx;

   logic [mse_pkg::CP_W-1:0] cp;
   logic is_ascii;
   logic [AIDX_W-1:0] aidx;
   logic [VEC_W-1:0] eq_ascii, eq_wide, eq, qbit, new_data;
   logic wfound;
   logic [WIDX_W-1:0] widx, wr_widx;
   logic q_fire, q_full, q_write;
   mse_pkg::store_wr_type wr_ctl;
   mse_pkg::step_ctl_type step_ctl;

   logic core_text_phase;
   logic [LEN_W-1:0] core_best;
   logic [POSITION_BITS-1:0] core_bcol;

   logic md_nonneg, ok;
   logic [LEN_W-1:0] dist_sel;
   logic [POSITION_BITS-1:0] pos_sel;
   logic [31:0] pos_wide;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign advance  = !(s2_valid_ff && (s2_item_ff.opcode == mse_pkg::OP_FINISH)) || out_free;
   assign req_stall = !advance;
   assign accept    = req_valid && advance;
   assign s2_finish_fire = advance && s2_valid_ff && (s2_item_ff.opcode == mse_pkg::OP_FINISH);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // stale: a finish retired after the item's lookups were issued
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_item_ff  <= req_item;
         s2_item_ff  <= s1_item_ff;
         s1_stale_ff <= s2_finish_fire;
         s2_stale_ff <= s1_stale_ff || s2_finish_fire;
      end
   end

   mse_match_store #(
      .QUERY_MAX     (QUERY_MAX),
      .ASCII_ENTRIES (ASCII_ENTRIES)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .rd_cp    (req_item.codepoint),
      .count    (count_ff),
      .clear    (s2_finish_fire),
      .wr_ctl   (wr_ctl),
      .wr_aidx  (aidx),
      .wr_widx  (wr_widx),
      .wr_code  (cp),
      .wr_data  (new_data),
      .ascii_rd (st_ascii_rd),
      .wide_rd  (st_wide_rd),
      .wide_hit (st_wide_hit),
      .wide_idx (st_wide_idx)
   );

   assign cp       = s2_item_ff.codepoint;
   assign is_ascii = cp < mse_pkg::CP_W'(ASCII_ENTRIES);
   assign aidx     = cp[AIDX_W-1:0];

   // match vector with the two most recent writes forwarded, newest first
   always_comb begin
      eq_ascii = s2_stale_ff ? '0 : st_ascii_rd;
      if (hist2_ff.valid && !hist2_ff.wide && (hist2_ff.aidx == aidx)) begin
         eq_ascii = hist2_ff.data;
      end
      if (hist1_ff.valid && !hist1_ff.wide && (hist1_ff.aidx == aidx)) begin
         eq_ascii = hist1_ff.data;
      end

      wfound = st_wide_hit && !s2_stale_ff;
      widx   = st_wide_idx;
      if (hist2_ff.valid && hist2_ff.append && (hist2_ff.code == cp)) begin
         wfound = 1'b1;
         widx   = hist2_ff.widx;
      end
      if (hist1_ff.valid && hist1_ff.append && (hist1_ff.code == cp)) begin
         wfound = 1'b1;
         widx   = hist1_ff.widx;
      end

      eq_wide = st_wide_rd;
      if (hist2_ff.valid && hist2_ff.wide && (hist2_ff.widx == widx)) begin
         eq_wide = hist2_ff.data;
      end
      if (hist1_ff.valid && hist1_ff.wide && (hist1_ff.widx == widx)) begin
         eq_wide = hist1_ff.data;
      end
      if (!wfound) begin
         eq_wide = '0;
      end

      eq = is_ascii ? eq_ascii : eq_wide;
   end

   assign q_fire   = advance && s2_valid_ff && (s2_item_ff.opcode == mse_pkg::OP_QUERY)
                     && !core_text_phase;
   assign q_full   = qlen_ff == LEN_W'(QUERY_MAX);
   assign q_write  = q_fire && !q_full;
   assign qbit     = {{(VEC_W-1){1'b0}}, 1'b1} << qlen_ff;
   assign new_data = eq | qbit;
   assign wr_widx  = wfound ? widx : count_ff[WIDX_W-1:0];

   assign wr_ctl.ascii_we = q_write && is_ascii;
   assign wr_ctl.wide_we  = q_write && !is_ascii;
   assign wr_ctl.code_we  = q_write && !is_ascii && !wfound;

   always_comb begin
      hist1_in.valid  = q_write;
      hist1_in.wide   = !is_ascii;
      hist1_in.append = wr_ctl.code_we;
      hist1_in.aidx   = aidx;
      hist1_in.widx   = wr_widx;
      hist1_in.code   = cp;
      hist1_in.data   = new_data;
      hist2_in        = hist1_ff;
      if (s2_finish_fire) begin
         hist2_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist1_ff.valid <= 1'b0;
         hist2_ff.valid <= 1'b0;
      end else if (advance) begin
         hist1_ff <= hist1_in;
         hist2_ff <= hist2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qlen_ff     <= '0;
         count_ff    <= '0;
         too_long_ff <= 1'b0;
      end else if (s2_finish_fire) begin
         qlen_ff     <= '0;
         count_ff    <= '0;
         too_long_ff <= 1'b0;
      end else if (q_fire) begin
         if (q_full) begin
            too_long_ff <= 1'b1;
         end else begin
            qlen_ff <= qlen_ff + LEN_W'(1);
         end
         if (wr_ctl.code_we) begin
            count_ff <= count_ff + LEN_W'(1);
         end
      end
   end

   assign step_ctl.text   = s2_item_ff.opcode == mse_pkg::OP_TEXT;
   assign step_ctl.finish = s2_item_ff.opcode == mse_pkg::OP_FINISH;
   assign step_ctl.active = !too_long_ff && (qlen_ff != '0);

   mse_bitvec #(
      .QUERY_MAX     (QUERY_MAX),
      .POSITION_BITS (POSITION_BITS)
   ) u_bitvec (
      .clock      (clock),
      .reset      (reset),
      .step       (advance && s2_valid_ff),
      .ctl        (step_ctl),
      .eq         (eq),
      .qlen       (qlen_ff),
      .text_phase (core_text_phase),
      .best_score (core_best),
      .best_col   (core_bcol)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '0;
      end else if (csr_wr_en) begin
         csr_ff <= csr_wr_data;
      end
   end

   always_comb begin
      md_nonneg = !csr_ff[mse_pkg::CSR_W-1];
      dist_sel  = '0;
      pos_sel   = '0;
      if (too_long_ff) begin
         md_nonneg = 1'b0;
      end else if (qlen_ff == '0) begin
         dist_sel = '0;
      end else if (!core_text_phase) begin
         dist_sel = qlen_ff;
      end else begin
         dist_sel = core_best;
         pos_sel  = core_bcol;
      end
      ok       = md_nonneg && (mse_pkg::CSR_W'(dist_sel) <= csr_ff);
      pos_wide = 32'(pos_sel);
      rsp_item_in.matched      = ok;
      rsp_item_in.distance     = ok ? mse_pkg::DIST_W'(dist_sel) : '0;
      rsp_item_in.end_position = ok ? pos_wide[mse_pkg::POS_OUT_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_finish_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_finish_fire) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   `MSE_ASSERT_HOLDS(a_count_le_qlen, clock, reset, count_ff <= qlen_ff, "more wide codes than query items")
   `MSE_ASSERT_NEXT(a_finish_clears, clock, reset, s2_finish_fire, (qlen_ff == '0) && (count_ff == '0) && !core_text_phase, "job not cleared")
   `MSE_ASSERT_NEXT(a_finish_result, clock, reset, s2_finish_fire, rsp_valid_ff, "finish gave no result")

endmodule

// ===== rtl/mse_match_store.sv =====
`include "myers_substring_edit_distance_top_assert.svh"

module mse_match_store #(
   parameter int QUERY_MAX     = mse_pkg::QUERY_MAX_DEF,
   parameter int ASCII_ENTRIES = mse_pkg::ASCII_ENTRIES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic [mse_pkg::CP_W-1:0]      rd_cp,
   input  logic [$clog2(QUERY_MAX+1)-1:0] count,
   input  logic                          clear,
   input  mse_pkg::store_wr_type         wr_ctl,
   input  logic [$clog2(ASCII_ENTRIES)-1:0] wr_aidx,
   input  logic [$clog2(QUERY_MAX)-1:0]  wr_widx,
   input  logic [mse_pkg::CP_W-1:0]      wr_code,
   input  logic [QUERY_MAX-1:0]          wr_data,
   output logic [QUERY_MAX-1:0]          ascii_rd,
   output logic [QUERY_MAX-1:0]          wide_rd,
   output logic                          wide_hit,
   output logic [$clog2(QUERY_MAX)-1:0]  wide_idx
);

   localparam int VEC_W  = QUERY_MAX;
   localparam int LEN_W  = $clog2(QUERY_MAX + 1);
   localparam int WIDX_W = $clog2(QUERY_MAX);
   localparam int AIDX_W = $clog2(ASCII_ENTRIES);

   logic [VEC_W-1:0]         ascii_mem [ASCII_ENTRIES];
   logic [ASCII_ENTRIES-1:0] ascii_vld_ff;
   logic [VEC_W-1:0]         wide_mem [QUERY_MAX];
   logic [mse_pkg::CP_W-1:0] code_ff [QUERY_MAX];

   logic [AIDX_W-1:0] rd_aidx;
   logic [QUERY_MAX-1:0] hit_in;
   logic [QUERY_MAX-1:0] hit1_ff;
   logic [WIDX_W-1:0] idx1;
   logic [VEC_W-1:0] ascii_rd1_ff;
   logic ascii_vld1_ff;
   logic [VEC_W-1:0] ascii_rd2_ff;
   logic [VEC_W-1:0] wide_rd2_ff;
   logic wide_hit2_ff;
   logic [WIDX_W-1:0] wide_idx2_ff;

   assign rd_aidx = (rd_cp < mse_pkg::CP_W'(ASCII_ENTRIES)) ? rd_cp[AIDX_W-1:0] : '0;

   // code cells compared in parallel, entries at or above count are stale
   always_comb begin
      for (int j = 0; j < QUERY_MAX; j++) begin
         hit_in[j] = (code_ff[j] == rd_cp) && (LEN_W'(j) < count);
      end
   end

   // codes are distinct, so at most one hit bit is set
   always_comb begin
      idx1 = '0;
      for (int j = 0; j < QUERY_MAX; j++) begin
         if (hit1_ff[j]) begin
            idx1 = idx1 | WIDX_W'(j);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_ctl.ascii_we) begin
         ascii_mem[wr_aidx] <= wr_data;
      end
      if (advance) begin
         ascii_rd1_ff <= ascii_mem[rd_aidx];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_ctl.wide_we) begin
         wide_mem[wr_widx] <= wr_data;
      end
      if (advance) begin
         wide_rd2_ff <= wide_mem[idx1];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_ctl.code_we) begin
         code_ff[wr_widx] <= wr_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ascii_vld_ff <= '0;
      end else if (clear) begin
         ascii_vld_ff <= '0;
      end else if (wr_ctl.ascii_we) begin
         ascii_vld_ff[wr_aidx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hit1_ff       <= hit_in;
         ascii_vld1_ff <= ascii_vld_ff[rd_aidx];
         ascii_rd2_ff  <= ascii_vld1_ff ? ascii_rd1_ff : '0;
         wide_hit2_ff  <= |hit1_ff;
         wide_idx2_ff  <= idx1;
      end
   end

   assign ascii_rd = ascii_rd2_ff;
   assign wide_rd  = wide_rd2_ff;
   assign wide_hit = wide_hit2_ff;
   assign wide_idx = wide_idx2_ff;

   `MSE_ASSERT_HOLDS(a_hit_onehot, clock, reset, $onehot0(hit1_ff), "duplicate wide code entries")

endmodule

// ===== rtl/mse_bitvec.sv =====
`include "myers_substring_edit_distance_top_assert.svh"

module mse_bitvec #(
   parameter int QUERY_MAX     = mse_pkg::QUERY_MAX_DEF,
   parameter int POSITION_BITS = mse_pkg::POSITION_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  mse_pkg::step_ctl_type          ctl,
   input  logic [QUERY_MAX-1:0]           eq,
   input  logic [$clog2(QUERY_MAX+1)-1:0] qlen,
   output logic                           text_phase,
   output logic [$clog2(QUERY_MAX+1)-1:0] best_score,
   output logic [POSITION_BITS-1:0]       best_col
);

   localparam int VEC_W  = QUERY_MAX;
   localparam int LEN_W  = $clog2(QUERY_MAX + 1);
   localparam int WIDX_W = $clog2(QUERY_MAX);

   logic text_phase_ff, text_phase_in;
   logic [VEC_W-1:0] vp_ff, vp_in, vm_ff, vm_in;
   logic [LEN_W-1:0] row_ff, row_in, best_ff, best_in;
   logic [POSITION_BITS-1:0] bcol_ff, bcol_in, col_ff, col_in;

   logic [VEC_W-1:0] cur_vp, cur_vm, x, d0, hp, hn, hp_sh, hn_sh;
   logic [LEN_W-1:0] cur_row, cur_best, row_new, top_len;
   logic [WIDX_W-1:0] topi;
   logic [POSITION_BITS-1:0] cur_bcol, col_next;
   logic better;

   always_comb begin
      // first text item of a job starts from a fresh column
      cur_vp   = text_phase_ff ? vp_ff : '1;
      cur_vm   = text_phase_ff ? vm_ff : '0;
      cur_row  = text_phase_ff ? row_ff : qlen;
      cur_best = text_phase_ff ? best_ff : qlen;
      cur_bcol = text_phase_ff ? bcol_ff : '0;
      col_next = (col_ff == '1) ? col_ff : col_ff + POSITION_BITS'(1);

      x     = eq | cur_vm;
      d0    = (((x & cur_vp) + cur_vp) ^ cur_vp) | x | cur_vm;
      hp    = cur_vm | ~(d0 | cur_vp);
      hn    = d0 & cur_vp;
      hp_sh = hp << 1;
      hn_sh = hn << 1;

      top_len = qlen - LEN_W'(1);
      topi    = top_len[WIDX_W-1:0];
      row_new = cur_row + LEN_W'(hp[topi]) - LEN_W'(hn[topi]);
      better  = row_new < cur_best;
   end

   always_comb begin
      text_phase_in = text_phase_ff;
      vp_in   = vp_ff;
      vm_in   = vm_ff;
      row_in  = row_ff;
      best_in = best_ff;
      bcol_in = bcol_ff;
      col_in  = col_ff;
      if (step && ctl.finish) begin
         text_phase_in = 1'b0;
         vp_in   = '1;
         vm_in   = '0;
         row_in  = '0;
         best_in = '0;
         bcol_in = '0;
         col_in  = '0;
      end else if (step && ctl.text) begin
         text_phase_in = 1'b1;
         col_in = col_next;
         if (ctl.active) begin
            vp_in   = hn_sh | ~(d0 | hp_sh);
            vm_in   = hp_sh & d0;
            row_in  = row_new;
            best_in = better ? row_new : cur_best;
            bcol_in = better ? col_next : cur_bcol;
         end else begin
            vp_in   = cur_vp;
            vm_in   = cur_vm;
            row_in  = cur_row;
            best_in = cur_best;
            bcol_in = cur_bcol;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_phase_ff <= 1'b0;
         vp_ff   <= '1;
         vm_ff   <= '0;
         row_ff  <= '0;
         best_ff <= '0;
         bcol_ff <= '0;
         col_ff  <= '0;
      end else begin
         text_phase_ff <= text_phase_in;
         vp_ff   <= vp_in;
         vm_ff   <= vm_in;
         row_ff  <= row_in;
         best_ff <= best_in;
         bcol_ff <= bcol_in;
         col_ff  <= col_in;
      end
   end

   assign text_phase = text_phase_ff;
   assign best_score = best_ff;
   assign best_col   = bcol_ff;

   `MSE_ASSERT_IMPLY(a_row_bound, clock, reset, text_phase_ff, row_ff <= qlen, "row score above query length")

endmodule

// ===== bench/myers_substring_edit_distance_top_tb.sv =====
module myers_substring_edit_distance_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [mse_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int POS_SAT = (1 << mse_pkg::POS_OUT_W) - 1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   mse_pkg::req_item_type req_item = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   mse_pkg::rsp_item_type rsp_item;
   logic csr_wr_en = 1'b0;
   logic [mse_pkg::CSR_W-1:0] csr_wr_data = '0;

   myers_substring_edit_distance_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // idle and stall odds, percent
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int errors = 0;
   int item_count = 0;

   // predictor state
   logic [63:0] ascii_masks [mse_pkg::ASCII_ENTRIES_DEF];
   logic [mse_pkg::CP_W-1:0] wide_codes [64];
   logic [63:0] wide_masks [64];
   int n_wide;
   int qlen;
   bit qlen_over;
   bit scanning;
   logic [63:0] pv, mv;
   int cur_score, low_score;
   int unsigned low_col, text_pos;
   int limit_dist = 0;

   mse_pkg::rsp_item_type pending_results[$];
   mse_pkg::rsp_item_type want;

   task automatic clear_job();
      foreach (ascii_masks[i]) ascii_masks[i] = '0;
      n_wide = 0;
      qlen = 0;
      qlen_over = 1'b0;
      scanning = 1'b0;
      pv = '1;
      mv = '0;
      cur_score = 0;
      low_score = 0;
      low_col = 0;
      text_pos = 0;
   endtask

   function automatic logic [63:0] match_mask(logic [mse_pkg::CP_W-1:0] cp);
      logic [63:0] m;
      m = '0;
      if (cp < mse_pkg::ASCII_ENTRIES_DEF) begin
         m = ascii_masks[cp];
      end else begin
         for (int j = n_wide - 1; j >= 0; j--) if (wide_codes[j] == cp) m = wide_masks[j];
      end
      return m;
   endfunction

   task automatic predict_item(mse_pkg::req_item_type it);
      logic [63:0] bitm, eq, x, d0, hp, hn, top;
      mse_pkg::rsp_item_type r;
      int dist_val;
      int unsigned pos;
      bit ok, hit;
      case (it.opcode)
         mse_pkg::OP_QUERY: begin
            if (!scanning) begin
               if (qlen >= mse_pkg::QUERY_MAX_DEF) begin
                  qlen_over = 1'b1;
               end else begin
                  bitm = 64'd1 << qlen;
                  qlen++;
                  if (it.codepoint < mse_pkg::ASCII_ENTRIES_DEF) begin
                     ascii_masks[it.codepoint] |= bitm;
                  end else begin
                     hit = 1'b0;
                     for (int j = 0; j < n_wide; j++) begin
                        if (!hit && wide_codes[j] == it.codepoint) begin
                           wide_masks[j] |= bitm;
                           hit = 1'b1;
                        end
                     end
                     if (!hit && n_wide < 64) begin
                        wide_codes[n_wide] = it.codepoint;
                        wide_masks[n_wide] = bitm;
                        n_wide++;
                     end
                  end
               end
            end
         end
         mse_pkg::OP_TEXT: begin
            if (!scanning) begin
               scanning = 1'b1;
               cur_score = qlen;
               low_score = qlen;
               low_col = 0;
               pv = '1;
               mv = '0;
            end
            if (text_pos < POS_SAT) text_pos++;
            if (!qlen_over && qlen != 0) begin
               top = 64'd1 << (qlen - 1);
               eq = match_mask(it.codepoint);
               x = eq | mv;
               d0 = (((x & pv) + pv) ^ pv) | x | mv;
               hp = mv | ~(d0 | pv);
               hn = d0 & pv;
               if ((hp & top) != 0) cur_score++;
               if ((hn & top) != 0) cur_score--;
               if (cur_score < low_score) begin
                  low_score = cur_score;
                  low_col = text_pos;
               end
               hp = hp << 1;
               hn = hn << 1;
               pv = hn | ~(d0 | hp);
               mv = hp & d0;
            end
         end
         mse_pkg::OP_FINISH: begin
            dist_val = 0;
            pos = 0;
            if (qlen_over) begin
               ok = 1'b0;
            end else if (qlen == 0) begin
               ok = limit_dist >= 0;
            end else if (!scanning) begin
               dist_val = qlen;
               ok = dist_val <= limit_dist;
            end else begin
               dist_val = low_score;
               pos = low_col;
               ok = dist_val <= limit_dist;
            end
            r.matched = ok;
            r.distance = ok ? dist_val[mse_pkg::DIST_W-1:0] : '0;
            r.end_position = ok ? pos[mse_pkg::POS_OUT_W-1:0] : '0;
            pending_results.push_back(r);
            clear_job();
         end
         default: ;
      endcase
   endtask

   // called and returns at a falling edge
   task automatic send_item(logic [mse_pkg::OP_W-1:0] op, logic [mse_pkg::CP_W-1:0] cp);
      mse_pkg::req_item_type it;
      it.opcode = op;
      it.codepoint = cp;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (req_stall);
      predict_item(it);
      item_count++;
      @(negedge clock);
   endtask

   task automatic send_chars(logic [mse_pkg::OP_W-1:0] op, string s);
      for (int i = 0; i < s.len(); i++) send_item(op, mse_pkg::CP_W'(s[i]));
   endtask

   task automatic set_max_distance(int v);
      logic [mse_pkg::CSR_W-1:0] b;
      b = v[mse_pkg::CSR_W-1:0];
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= b;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      limit_dist = int'($signed(b));
   endtask

   always @(negedge clock) begin
      rsp_stall <= (rsp_stall_pct != 0) && ($urandom_range(99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result matched=%0d distance=%0d end_position=%0d",
                     $time, rsp_item.matched, rsp_item.distance, rsp_item.end_position);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_item.matched !== want.matched) begin
               $display("%0t: matched expected %0d actual %0d",
                        $time, want.matched, rsp_item.matched);
               errors++;
            end
            if (rsp_item.distance !== want.distance) begin
               $display("%0t: distance expected %0d actual %0d",
                        $time, want.distance, rsp_item.distance);
               errors++;
            end
            if (rsp_item.end_position !== want.end_position) begin
               $display("%0t: end_position expected %0d actual %0d",
                        $time, want.end_position, rsp_item.end_position);
               errors++;
            end
         end
      end
   end

   // max distance at its reset value of 0
   task automatic test_reset_value();
      send_item(mse_pkg::OP_FINISH, 21'd0);
      send_chars(mse_pkg::OP_QUERY, "a");
      send_chars(mse_pkg::OP_TEXT, "ba");
      send_item(mse_pkg::OP_FINISH, 21'h10FFFF);
      send_chars(mse_pkg::OP_QUERY, "ab");
      send_item(mse_pkg::OP_FINISH, 21'd0);
   endtask

   task automatic test_basic_matching();
      set_max_distance(64);
      send_chars(mse_pkg::OP_QUERY, "abc");
      send_item(OP_UNUSED, 21'h0F0000);
      send_chars(mse_pkg::OP_TEXT, "xabxc");
      send_chars(mse_pkg::OP_QUERY, "b");
      send_item(mse_pkg::OP_FINISH, 21'd0);
      send_item(mse_pkg::OP_QUERY, 21'h10FFFF);
      send_item(mse_pkg::OP_QUERY, 21'h0F0000);
      send_item(mse_pkg::OP_QUERY, 21'h000080);
      send_item(mse_pkg::OP_QUERY, 21'h00007F);
      send_item(mse_pkg::OP_QUERY, 21'h000000);
      send_item(mse_pkg::OP_TEXT, 21'h000000);
      send_item(mse_pkg::OP_TEXT, 21'h10FFFF);
      send_item(mse_pkg::OP_TEXT, 21'h0F0000);
      send_item(mse_pkg::OP_TEXT, 21'h000080);
      send_item(mse_pkg::OP_TEXT, 21'h00007F);
      send_item(mse_pkg::OP_TEXT, 21'h000000);
      send_item(mse_pkg::OP_FINISH, 21'd0);
      send_chars(mse_pkg::OP_QUERY, "xyz");
      send_item(mse_pkg::OP_FINISH, 21'd0);
      send_item(mse_pkg::OP_FINISH, 21'd0);
   endtask

   task automatic test_reject_all();
      set_max_distance(-1);
      send_item(mse_pkg::OP_FINISH, 21'd0);
      send_chars(mse_pkg::OP_QUERY, "a");
      send_chars(mse_pkg::OP_TEXT, "a");
      send_item(mse_pkg::OP_FINISH, 21'd0);
      set_max_distance(-128);
      send_item(mse_pkg::OP_FINISH, 21'd0);
      set_max_distance(127);
      send_chars(mse_pkg::OP_QUERY, "ab");
      send_item(mse_pkg::OP_FINISH, 21'd0);
   endtask

   // full-length queries, a full wide store, and a query one too long
   task automatic test_query_limits();
      set_max_distance(64);
      for (int i = 0; i < mse_pkg::QUERY_MAX_DEF; i++)
         send_item(mse_pkg::OP_QUERY, mse_pkg::CP_W'(97 + i % 26));
      for (int i = 0; i < mse_pkg::QUERY_MAX_DEF; i++)
         send_item(mse_pkg::OP_TEXT, mse_pkg::CP_W'(97 + i % 26));
      send_item(mse_pkg::OP_FINISH, 21'd0);
      for (int i = 0; i < mse_pkg::QUERY_MAX_DEF; i++)
         send_item(mse_pkg::OP_QUERY, mse_pkg::CP_W'(200000 + i * 13000));
      for (int i = 10; i >= 0; i--)
         send_item(mse_pkg::OP_TEXT, mse_pkg::CP_W'(200000 + i * 13000));
      for (int i = 50; i < mse_pkg::QUERY_MAX_DEF; i++)
         send_item(mse_pkg::OP_TEXT, mse_pkg::CP_W'(200000 + i * 13000));
      send_item(mse_pkg::OP_FINISH, 21'd0);
      for (int i = 0; i <= mse_pkg::QUERY_MAX_DEF; i++)
         send_item(mse_pkg::OP_QUERY, mse_pkg::CP_W'(97 + i % 3));
      send_chars(mse_pkg::OP_TEXT, "abcabc");
      send_item(mse_pkg::OP_FINISH, 21'd0);
   endtask

   function automatic logic [mse_pkg::CP_W-1:0] random_code();
      case ($urandom_range(3))
         0, 1: return mse_pkg::CP_W'($urandom_range(0, 127));
         2: return mse_pkg::CP_W'($urandom_range(128, 1114111));
         default: return mse_pkg::CP_W'($urandom_range(128, 140));
      endcase
   endfunction

   task automatic random_job();
      logic [mse_pkg::CP_W-1:0] alpha [6];
      logic [mse_pkg::CP_W-1:0] qcps[$];
      logic [mse_pkg::CP_W-1:0] cp;
      int r, qn, tn, start;
      foreach (alpha[k]) alpha[k] = random_code();
      r = $urandom_range(99);
      if (r < 5) qn = 0;
      else if (r < 10) qn = $urandom_range(13, mse_pkg::QUERY_MAX_DEF);
      else if (r < 13) qn = $urandom_range(mse_pkg::QUERY_MAX_DEF + 1,
                                           mse_pkg::QUERY_MAX_DEF + 3);
      else qn = $urandom_range(1, 12);
      for (int i = 0; i < qn; i++) begin
         cp = alpha[$urandom_range(5)];
         qcps.push_back(cp);
         send_item(mse_pkg::OP_QUERY, cp);
         if ($urandom_range(99) < 3)
            send_item(OP_UNUSED, mse_pkg::CP_W'($urandom_range(0, 1114111)));
      end
      tn = ($urandom_range(99) < 8) ? 0 : $urandom_range(1, 24);
      start = (qn > 0) ? $urandom_range(0, qn - 1) : 0;
      for (int i = 0; i < tn; i++) begin
         r = $urandom_range(99);
         if (qn > 0 && r < 65) cp = qcps[(start + i) % qn];
         else if (r < 92) cp = alpha[$urandom_range(5)];
         else cp = mse_pkg::CP_W'($urandom_range(0, 1114111));
         send_item(mse_pkg::OP_TEXT, cp);
         r = $urandom_range(99);
         if (r < 3) send_item(OP_UNUSED, random_code());
         else if (r < 6) send_item(mse_pkg::OP_QUERY, alpha[$urandom_range(5)]);
      end
      send_item(mse_pkg::OP_FINISH, mse_pkg::CP_W'($urandom_range(0, 1114111)));
   endtask

   task automatic test_random();
      int limits [8];
      int target;
      limits = '{0, -1, 64, 127, -128, 5, 0, 0};
      limits[6] = $urandom_range(0, 65) - 1;
      limits[7] = $urandom_range(0, 65) - 1;
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 45; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 45; end
            default: begin send_idle_pct = 32; rsp_stall_pct = 32; end
         endcase
         for (int s = 0; s < 2; s++) begin
            set_max_distance(limits[ph * 2 + s]);
            target = item_count + 115;
            while (item_count < target) random_job();
         end
      end
   endtask

   initial begin
      clear_job();
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      test_reset_value();
      test_basic_matching();
      test_reject_all();
      test_query_limits();
      test_random();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
